[sv/atr_pkg.sv]
`default_nettype none
package atr_pkg;
  localparam int unsigned TsW = 64;
  localparam int unsigned TypeW = 3;
  localparam int unsigned CfgW = 32;
  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgW-1:0] JumpThrReset = 32'd10000;
  localparam logic [CfgW-1:0] BackThrReset = 32'd2000;
  localparam logic [CfgW-1:0] SwitchThrReset = 32'd100000;
  localparam logic [CfgW-1:0] MergeDeltaReset = 32'd2000;
  localparam logic [CntW-1:0] UnsyncLimitReset = 16'd600;

  localparam logic [CfgIdxW-1:0] RegJumpThr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBackThr = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSwitchThr = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMergeDelta = 3'd3;
  localparam logic [CfgIdxW-1:0] RegUnsyncLimit = 3'd4;

  localparam logic [TypeW-1:0] TrkAudio = 3'd0;
  localparam logic [TypeW-1:0] TrkVideo = 3'd1;
  localparam logic [TypeW-1:0] TrkSub = 3'd2;
  localparam logic [TypeW-1:0] TrkTag = 3'd3;

  typedef enum logic [1:0] {
    MODE_AV = 2'd0,
    MODE_AUDIO = 2'd1,
    MODE_VIDEO = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_SEEK,
    CMD_TAG,
    CMD_PASS,
    CMD_AUDIO,
    CMD_VIDEO,
    CMD_SUB
  } cmd_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t cmd;
    logic [TypeW-1:0] track_type;
    logic [TsW-1:0] timestamp;
    logic new_format;
    logic track_unavailable;
    logic chunk_dropped;
    logic chunk_begin;
    logic chunk_switch;
    logic discontinuous;
  } req_t;

  typedef struct packed {
    logic [CfgW-1:0] jump_thr;
    logic [CfgW-1:0] back_thr;
    logic [CfgW-1:0] switch_thr;
    logic [CfgW-1:0] merge_delta;
    logic [CntW-1:0] unsync_limit;
  } cfg_t;
endpackage
`default_nettype wire

[sv/atr_if.sv]
`default_nettype none
interface atr_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [2:0] track_type;
  logic [63:0] timestamp;
  logic new_format;
  logic track_unavailable;
  logic chunk_dropped;
  logic chunk_begin;
  logic chunk_switch;
  logic discontinuous;
  logic internal_subtitle;
  modport source(output valid, op, track_type, timestamp, new_format, track_unavailable,
    chunk_dropped, chunk_begin, chunk_switch, discontinuous, internal_subtitle,
    input ready);
  modport sink(input valid, op, track_type, timestamp, new_format, track_unavailable,
    chunk_dropped, chunk_begin, chunk_switch, discontinuous, internal_subtitle,
    output ready);
endinterface

interface atr_out_if;
  logic valid;
  logic ready;
  logic [63:0] out_timestamp;
  logic rewritten;
  modport source(output valid, out_timestamp, rewritten, input ready);
  modport sink(input valid, out_timestamp, rewritten, output ready);
endinterface
`default_nettype wire

[sv/atr_front.sv]
`default_nettype none
module atr_front
  import atr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  atr_in_if.sink    in_ch,
  output req_t      q_req,
  output logic      q_valid,
  input  wire logic q_pop
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  req_t slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntBits-1:0] count;
  req_t cls;
  logic push;

  // classify
  always_comb begin
    cls.track_type = in_ch.track_type;
    cls.timestamp = in_ch.timestamp;
    cls.new_format = in_ch.new_format;
    cls.track_unavailable = in_ch.track_unavailable;
    cls.chunk_dropped = in_ch.chunk_dropped;
    cls.chunk_begin = in_ch.chunk_begin;
    cls.chunk_switch = in_ch.chunk_switch;
    cls.discontinuous = in_ch.discontinuous;
    if (in_ch.op) cls.cmd = CMD_SEEK;
    else if (in_ch.track_type == TrkTag) cls.cmd = CMD_TAG;
    else if (in_ch.track_unavailable) cls.cmd = CMD_PASS;
    else if (in_ch.track_type == TrkAudio) cls.cmd = CMD_AUDIO;
    else if (in_ch.track_type == TrkVideo) cls.cmd = CMD_VIDEO;
    else if (in_ch.track_type == TrkSub && in_ch.internal_subtitle) cls.cmd = CMD_SUB;
    else cls.cmd = CMD_PASS;
  end

  assign in_ch.ready = (count != CntBits'(Depth));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != '0);
  assign q_req = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CntBits'(push) - CntBits'(q_pop);
    end
  end
endmodule
`default_nettype wire

[sv/atr_back.sv]
`default_nettype none
module atr_back
  import atr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  req_t      q_req,
  input  wire logic q_valid,
  output logic      q_pop,
  atr_out_if.source out_ch
);
  typedef enum logic [0:0] {
    PH_DECIDE = 1'b0,
    PH_COMMIT = 1'b1
  } phase_t;

  phase_t phase, phase_next;

  mode_t media_mode;
  logic [TsW-1:0] last_audio_raw, last_video_raw, audio_shift, video_shift;
  logic [TsW-1:0] subtitle_shift, start_position, last_audio_out, last_video_out;
  logic audio_pending, video_pending, subtitle_pending;
  logic [CntW-1:0] unsync_count;

  // stage-1 registers
  logic [TsW-1:0] s_shift;
  logic [TsW-1:0] s_r;
  logic s_is_audio;

  logic out_full;
  logic out_free;
  logic out_load;

  // decide-phase combinational values
  logic is_a;
  logic [TsW-1:0] t, last_raw, own_shift, oth_shift, d;
  logic own_pend, oth_pend, rebase, big, back;
  logic [TsW-1:0] shift_new;

  // commit-phase values
  logic [TsW-1:0] hi, lo, md, r_fin, a_sh_c, v_sh_c;
  logic [CntW-1:0] cnt_inc;
  logic merge_ok, do_merge;

  assign out_free = !out_full || out_ch.ready;
  // every pop except a seek loads the output register
  assign out_load = q_pop && (q_req.cmd != CMD_SEEK);

  always_comb begin
    t = q_req.timestamp;
    is_a = (q_req.cmd == CMD_AUDIO);
    last_raw = is_a ? last_audio_raw : last_video_raw;
    own_shift = is_a ? audio_shift : video_shift;
    oth_shift = is_a ? video_shift : audio_shift;
    own_pend = is_a ? audio_pending : video_pending;
    oth_pend = is_a ? video_pending : audio_pending;
    if (q_req.chunk_dropped && t > last_raw && !own_pend) last_raw = t;
    d = (t > last_raw) ? t - last_raw : last_raw - t;
    back = t < last_raw;
    big = d > TsW'(cfg.jump_thr) || (d > TsW'(cfg.back_thr) && back);
    if (own_pend) rebase = 1'b1;
    else if (big && q_req.chunk_switch)
      rebase = d > TsW'(cfg.switch_thr) || q_req.discontinuous;
    else rebase = big;
    if (!rebase) shift_new = own_shift;
    else if (!oth_pend && own_pend) shift_new = oth_shift;
    else shift_new = own_shift + last_raw + 64'd1 - t;
  end

  // commit: mode follow, merge, clamp
  always_comb begin
    a_sh_c = s_is_audio ? s_shift : audio_shift;
    v_sh_c = s_is_audio ? video_shift : s_shift;
    if (s_is_audio && media_mode == MODE_AUDIO) v_sh_c = s_shift;
    if (!s_is_audio && media_mode == MODE_VIDEO) a_sh_c = s_shift;
    hi = (v_sh_c > a_sh_c) ? v_sh_c : a_sh_c;
    lo = (v_sh_c > a_sh_c) ? a_sh_c : v_sh_c;
    md = hi - lo;
    cnt_inc = (unsync_count != 16'hFFFF) ? unsync_count + 1'b1 : unsync_count;
    merge_ok = (v_sh_c != a_sh_c) && !(s_is_audio ? video_pending : audio_pending);
    do_merge = merge_ok && (md[TsW-1] || md <= TsW'(cfg.merge_delta) ||
      (cnt_inc > cfg.unsync_limit && q_req.chunk_begin && media_mode == MODE_AV));
    r_fin = s_r[TsW-1] ? '0 : s_r;
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_DECIDE: if (q_valid && (q_req.cmd == CMD_AUDIO || q_req.cmd == CMD_VIDEO))
        phase_next = PH_COMMIT;
      PH_COMMIT: if (out_free) phase_next = PH_DECIDE;
      default: phase_next = PH_DECIDE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    case (phase)
      PH_DECIDE: q_pop = q_valid && (q_req.cmd == CMD_SEEK ||
        ((q_req.cmd == CMD_TAG || q_req.cmd == CMD_PASS || q_req.cmd == CMD_SUB) && out_free));
      PH_COMMIT: q_pop = out_free;
      default: q_pop = 1'b0;
    endcase
  end

  assign out_ch.valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) phase <= PH_DECIDE;
    else phase <= phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      media_mode <= MODE_AV;
      last_audio_raw <= '0;
      last_video_raw <= '0;
      audio_shift <= '0;
      video_shift <= '0;
      subtitle_shift <= '0;
      start_position <= '0;
      last_audio_out <= '0;
      last_video_out <= '0;
      audio_pending <= 1'b1;
      video_pending <= 1'b1;
      subtitle_pending <= 1'b1;
      unsync_count <= '0;
    end else begin
      out_full <= out_load || (out_full && !out_ch.ready);
      if (phase == PH_DECIDE && q_valid) begin
        case (q_req.cmd)
          CMD_SEEK: begin
            last_audio_raw <= '0;
            last_video_raw <= '0;
            audio_shift <= '0;
            video_shift <= '0;
            subtitle_shift <= '0;
            start_position <= t;
            audio_pending <= 1'b1;
            video_pending <= 1'b1;
            subtitle_pending <= 1'b1;
          end
          CMD_TAG: if (out_free) begin
            out_ch.rewritten <= 1'b1;
            if (!audio_pending) out_ch.out_timestamp <= last_audio_out;
            else if (!video_pending) out_ch.out_timestamp <= last_video_out;
            else out_ch.out_timestamp <= start_position;
          end
          CMD_PASS: if (out_free) begin
            out_ch.rewritten <= 1'b0;
            out_ch.out_timestamp <= t;
            if (q_req.new_format) begin
              if (q_req.track_type == TrkAudio && media_mode == MODE_VIDEO)
                media_mode <= MODE_AV;
              else if (q_req.track_type == TrkVideo && media_mode == MODE_AUDIO)
                media_mode <= MODE_AV;
            end else if (q_req.track_unavailable && media_mode == MODE_AV) begin
              if (q_req.track_type == TrkAudio) media_mode <= MODE_VIDEO;
              else if (q_req.track_type == TrkVideo) media_mode <= MODE_AUDIO;
            end
          end
          CMD_SUB: if (out_free) begin
            out_ch.rewritten <= 1'b1;
            if (!video_pending) begin
              out_ch.out_timestamp <= ((t + video_shift + start_position) >> (TsW-1)) != 0
                ? '0 : t + video_shift + start_position;
            end else if (!audio_pending) begin
              out_ch.out_timestamp <= ((t + audio_shift + start_position) >> (TsW-1)) != 0
                ? '0 : t + audio_shift + start_position;
            end else if (subtitle_pending) begin
              subtitle_pending <= 1'b0;
              subtitle_shift <= subtitle_shift - t;
              out_ch.out_timestamp <= '0;
            end else begin
              out_ch.out_timestamp <= (t + subtitle_shift) >> (TsW-1) != 0
                ? '0 : t + subtitle_shift;
            end
          end
          CMD_AUDIO, CMD_VIDEO: begin
            if (q_req.new_format) begin
              if (is_a && media_mode == MODE_VIDEO) media_mode <= MODE_AV;
              else if (!is_a && media_mode == MODE_AUDIO) media_mode <= MODE_AV;
            end
            s_is_audio <= is_a;
            s_shift <= shift_new;
            s_r <= t + shift_new + start_position;
            if (is_a) begin
              audio_pending <= 1'b0;
              last_audio_raw <= t;
              if (media_mode == MODE_AUDIO) last_video_raw <= t;
            end else begin
              video_pending <= 1'b0;
              last_video_raw <= t;
              if (media_mode == MODE_VIDEO) last_audio_raw <= t;
            end
          end
          default: ;
        endcase
      end
      if (phase == PH_COMMIT && out_free) begin
        out_ch.rewritten <= 1'b1;
        out_ch.out_timestamp <= r_fin;
        if (s_is_audio) last_audio_out <= r_fin;
        else last_video_out <= r_fin;
        if (merge_ok) unsync_count <= cnt_inc;
        else unsync_count <= '0;
        audio_shift <= do_merge ? hi : a_sh_c;
        video_shift <= do_merge ? hi : v_sh_c;
      end
    end
  end
endmodule
`default_nettype wire

[sv/av_timestamp_rebaser_top.sv]
// Seek gives no result; tag, pass-through and subtitle requests reach the output register
//   from the decide phase, audio/video requests from the commit phase after decide.
// Audio/video requests hold the back end through decide and commit, others only decide;
// this comes from the dependent 64-bit shift update and merge through the back end.
// Reset (rst, synchronous): thresholds return to defaults, state clears, queue empties.
`default_nettype none
module av_timestamp_rebaser_top
  import atr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  atr_in_if.sink                  in_ch,
  atr_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data
);
  cfg_t cfg;
  req_t q_req;
  logic q_valid, q_pop;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_thr <= JumpThrReset;
      cfg.back_thr <= BackThrReset;
      cfg.switch_thr <= SwitchThrReset;
      cfg.merge_delta <= MergeDeltaReset;
      cfg.unsync_limit <= UnsyncLimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegJumpThr: cfg.jump_thr <= cfg_data;
        RegBackThr: cfg.back_thr <= cfg_data;
        RegSwitchThr: cfg.switch_thr <= cfg_data;
        RegMergeDelta: cfg.merge_delta <= cfg_data;
        RegUnsyncLimit: cfg.unsync_limit <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  // front: classify and queue requests
  atr_front #(.Depth(Depth)) u_front (
    .clk, .rst, .in_ch, .q_req, .q_valid, .q_pop
  );

  // back: state update and output register
  atr_back u_back (
    .clk, .rst, .cfg, .q_req, .q_valid, .q_pop, .out_ch
  );
endmodule
`default_nettype wire

[verif/atr_tb_if.sv]
`timescale 1ns / 1ps
// Channels are taken from the RTL interface file (atr_in_if / atr_out_if).
// This file holds the shared request record used by the checker and the top.
package atr_tb_pkg;
  typedef struct {
    bit          op;
    bit [2:0]    track_type;
    bit [63:0]   timestamp;
    bit          new_format;
    bit          track_unavailable;
    bit          chunk_dropped;
    bit          chunk_begin;
    bit          chunk_switch;
    bit          discontinuous;
    bit          internal_subtitle;
  } sample_req_t;
endpackage

[verif/atr_rebase_checker.sv]
`timescale 1ns / 1ps
module atr_rebase_checker
  import atr_pkg::*;
  import atr_tb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  atr_in_if                       in_ch,
  atr_out_if                      out_ch,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  output int                      fail_count,
  output int                      pending_count
);
  localparam bit [63:0] TopBit = 64'h8000_0000_0000_0000;

  bit [63:0] jump_thr, back_thr, switch_thr, merge_dlt, unsync_lim;
  mode_t     mode;
  bit [63:0] a_raw, v_raw, a_shift, v_shift, s_shift, start_pos, a_out, v_out;
  bit        a_pend, v_pend, s_pend;
  bit [15:0] unsync_cnt;

  typedef struct {
    bit [63:0] ts;
    bit        rew;
  } stamp_t;
  stamp_t expected_stamps[$];

  assign pending_count = expected_stamps.size();

  function automatic bit needs_rebase(bit [63:0] last, bit [63:0] t, bit force_it,
                                      bit sw, bit disc);
    bit [63:0] d;
    d = (t > last) ? t - last : last - t;
    if (force_it) return 1;
    if (d > jump_thr || (d > back_thr && t < last)) begin
      if (sw) return (d > switch_thr) || disc;
      return 1;
    end
    return 0;
  endfunction

  task automatic merge_offsets(bit cbegin);
    bit [63:0] hi, lo, d;
    if (v_shift != a_shift && !a_pend && !v_pend) begin
      hi = (v_shift > a_shift) ? v_shift : a_shift;
      lo = (v_shift > a_shift) ? a_shift : v_shift;
      d = hi - lo;
      if (unsync_cnt != 16'hFFFF) unsync_cnt++;
      if ((d & TopBit) != 0 || d <= merge_dlt ||
          (unsync_cnt > unsync_lim && cbegin && mode == MODE_AV)) begin
        v_shift = hi;
        a_shift = hi;
      end
    end else begin
      unsync_cnt = 0;
    end
  endtask

  // Rebases one sample; returns 1 and the stamp when a result is due.
  task automatic rebase_sample(sample_req_t q, output bit has, output stamp_t s);
    bit [63:0] t, r;
    t = q.timestamp;
    has = 0;
    s.ts = t;
    s.rew = 0;
    if (q.op) begin
      a_raw = 0; v_raw = 0; a_shift = 0; v_shift = 0; s_shift = 0;
      start_pos = t;
      a_pend = 1; v_pend = 1; s_pend = 1;
      return;
    end
    has = 1;
    if (q.track_type == TrkTag) begin
      s.ts = !a_pend ? a_out : (!v_pend ? v_out : start_pos);
      s.rew = 1;
      return;
    end
    if (q.new_format) begin
      if (q.track_type == TrkAudio && mode == MODE_VIDEO) mode = MODE_AV;
      else if (q.track_type == TrkVideo && mode == MODE_AUDIO) mode = MODE_AV;
    end else if (q.track_unavailable) begin
      if (q.track_type == TrkAudio && mode == MODE_AV) mode = MODE_VIDEO;
      else if (q.track_type == TrkVideo && mode == MODE_AV) mode = MODE_AUDIO;
    end
    if (q.track_unavailable) return;
    if (q.track_type == TrkAudio) begin
      if (q.chunk_dropped && t > a_raw && !a_pend) a_raw = t;
      if (needs_rebase(a_raw, t, a_pend, q.chunk_switch, q.discontinuous)) begin
        if (!v_pend && a_pend) a_shift = v_shift;
        else a_shift = a_shift + (a_raw + 1) - t;
      end
      a_pend = 0;
      a_raw = t;
      r = t + a_shift;
      if (mode == MODE_AUDIO) begin
        v_shift = a_shift;
        v_raw = a_raw;
      end
      merge_offsets(q.chunk_begin);
    end else if (q.track_type == TrkVideo) begin
      if (q.chunk_dropped && t > v_raw && !v_pend) v_raw = t;
      if (needs_rebase(v_raw, t, v_pend, q.chunk_switch, q.discontinuous)) begin
        if (!a_pend && v_pend) v_shift = a_shift;
        else v_shift = v_shift + (v_raw + 1) - t;
      end
      v_pend = 0;
      v_raw = t;
      r = t + v_shift;
      if (mode == MODE_VIDEO) begin
        a_shift = v_shift;
        a_raw = v_raw;
      end
      merge_offsets(q.chunk_begin);
    end else if (q.track_type == TrkSub && q.internal_subtitle) begin
      if (!v_pend) r = t + v_shift;
      else if (!a_pend) r = t + a_shift;
      else if (s_pend) begin
        s_pend = 0;
        s_shift = s_shift - t;
        r = 0 - start_pos;
      end else r = t + s_shift - start_pos;
    end else begin
      return;
    end
    r += start_pos;
    if ((r & TopBit) != 0) r = 0;
    if (q.track_type == TrkAudio) a_out = r;
    else if (q.track_type == TrkVideo) v_out = r;
    s.ts = r;
    s.rew = 1;
  endtask

  always @(posedge clk) begin
    sample_req_t q;
    stamp_t s, e;
    bit has;
    if (rst) begin
      jump_thr = 10000; back_thr = 2000; switch_thr = 100000;
      merge_dlt = 2000; unsync_lim = 600;
      mode = MODE_AV;
      a_raw = 0; v_raw = 0; a_shift = 0; v_shift = 0; s_shift = 0; start_pos = 0;
      a_out = 0; v_out = 0;
      a_pend = 1; v_pend = 1; s_pend = 1;
      unsync_cnt = 0;
      expected_stamps.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegJumpThr:     jump_thr = 64'(cfg_data);
          RegBackThr:     back_thr = 64'(cfg_data);
          RegSwitchThr:   switch_thr = 64'(cfg_data);
          RegMergeDelta:  merge_dlt = 64'(cfg_data);
          RegUnsyncLimit: unsync_lim = 64'(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_stamps.size() == 0) begin
          $display("%0t unexpected result ts=%h rew=%b", $realtime,
                   out_ch.out_timestamp, out_ch.rewritten);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_stamps.pop_front();
          if (e.ts !== out_ch.out_timestamp || e.rew !== out_ch.rewritten) begin
            $display("%0t mismatch: expected ts=%h rew=%b, got ts=%h rew=%b", $realtime,
                     e.ts, e.rew, out_ch.out_timestamp, out_ch.rewritten);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        q.op = in_ch.op;
        q.track_type = in_ch.track_type;
        q.timestamp = in_ch.timestamp;
        q.new_format = in_ch.new_format;
        q.track_unavailable = in_ch.track_unavailable;
        q.chunk_dropped = in_ch.chunk_dropped;
        q.chunk_begin = in_ch.chunk_begin;
        q.chunk_switch = in_ch.chunk_switch;
        q.discontinuous = in_ch.discontinuous;
        q.internal_subtitle = in_ch.internal_subtitle;
        rebase_sample(q, has, s);
        if (has) expected_stamps.push_back(s);
      end
    end
  end
endmodule

[verif/tb_av_timestamp_rebaser_top.sv]
`timescale 1ns / 1ps
module tb_av_timestamp_rebaser_top;
  import atr_pkg::*;
  import atr_tb_pkg::*;

  localparam int StallLimit = 20000;  // idle cycles before the watchdog trips

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit hold_off = 0;   // long receiver stall request, set by the stimulus
  bit done = 0;

  atr_in_if in_ch();
  atr_out_if out_ch();

  av_timestamp_rebaser_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  atr_rebase_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Receiver: its own stall pattern, with calm stretches and an optional long hold.
  always @(posedge clk) begin
    int mode_sel;
    int hold;
    if (rst) begin
      out_ch.ready <= 0;
      mode_sel = 0;
      hold = 0;
    end else begin
      if (hold_off && hold == 0) hold = 400;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode_sel = $urandom_range(0, 2);
        case (mode_sel)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("[av_timestamp_rebaser_top] ERROR");
      $finish;
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  // Drives one request, holding valid until it is taken.
  task automatic send_request(sample_req_t q);
    if (burst_left == 0 && gap_left > 0) begin
      in_ch.valid <= 0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    in_ch.valid <= 1;
    in_ch.op <= q.op;
    in_ch.track_type <= q.track_type;
    in_ch.timestamp <= q.timestamp;
    in_ch.new_format <= q.new_format;
    in_ch.track_unavailable <= q.track_unavailable;
    in_ch.chunk_dropped <= q.chunk_dropped;
    in_ch.chunk_begin <= q.chunk_begin;
    in_ch.chunk_switch <= q.chunk_switch;
    in_ch.discontinuous <= q.discontinuous;
    in_ch.internal_subtitle <= q.internal_subtitle;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  function automatic sample_req_t make_req(bit op, bit [2:0] trk, bit [63:0] ts,
                                           bit [6:0] flags);
    sample_req_t q;
    q.op = op; q.track_type = trk; q.timestamp = ts;
    {q.new_format, q.track_unavailable, q.chunk_dropped, q.chunk_begin,
     q.chunk_switch, q.discontinuous, q.internal_subtitle} = flags;
    return q;
  endfunction

  // Wait for all results, then let a trailing seek, which gives no result, drain the pipe.
  task automatic wait_idle();
    in_ch.valid <= 0;
    burst_left = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Mostly plausible media streams: audio and video creeping forward with
  // occasional jumps, backward steps, seeks, tags and subtitles.
  task automatic random_stream(int count);
    bit [63:0] a_t, v_t, ts;
    bit [2:0] trk;
    bit [6:0] flags;
    int k;
    a_t = $urandom_range(0, 50000);
    v_t = a_t;
    for (k = 0; k < count; k++) begin
      flags = 0;
      flags[3] = ($urandom_range(0, 7) == 0);           // chunk begin
      flags[2] = ($urandom_range(0, 9) == 0);           // chunk switch
      flags[1] = ($urandom_range(0, 11) == 0);          // discontinuous
      flags[4] = ($urandom_range(0, 11) == 0);          // chunk dropped
      flags[0] = 1'($urandom_range(0, 1));              // internal subtitle
      flags[6] = ($urandom_range(0, 24) == 0);          // new format
      flags[5] = ($urandom_range(0, 29) == 0);          // unavailable
      case ($urandom_range(0, 19))
        0: trk = TrkTag;
        1, 2: trk = TrkSub;
        3: trk = 3'($urandom_range(4, 7));
        4, 5, 6, 7, 8, 9, 10, 11: trk = TrkAudio;
        default: trk = TrkVideo;
      endcase
      ts = (trk == TrkVideo) ? v_t : a_t;
      case ($urandom_range(0, 15))
        0: ts = ts + $urandom_range(2001, 300000);
        1: ts = ts - $urandom_range(0, 20000);
        2: ts = {$urandom, $urandom};
        default: ts = ts + $urandom_range(0, 60);
      endcase
      if (trk == TrkVideo) v_t = ts; else if (trk == TrkAudio) a_t = ts;
      if ($urandom_range(0, 79) == 0) begin
        send_request(make_req(1, 3'($urandom_range(0, 7)), $urandom_range(0, 1) ?
                              64'($urandom_range(0, 100000)) : {$urandom, $urandom}, 0));
        a_t = $urandom_range(0, 50000);
        v_t = a_t;
      end else begin
        send_request(make_req(0, trk, ts, flags));
      end
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.op = 0; in_ch.track_type = 0; in_ch.timestamp = 0;
    in_ch.new_format = 0; in_ch.track_unavailable = 0; in_ch.chunk_dropped = 0;
    in_ch.chunk_begin = 0; in_ch.chunk_switch = 0; in_ch.discontinuous = 0;
    in_ch.internal_subtitle = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: fresh start, merge, jumps, tags, subtitles, mode changes, clamp.
    send_request(make_req(0, TrkTag, 64'd5, 7'h7F));           // tag before any media
    send_request(make_req(0, TrkSub, 64'd123, 7'b0000001));    // first internal subtitle
    send_request(make_req(0, TrkSub, 64'd200, 7'b0000001));
    send_request(make_req(0, TrkSub, 64'd300, 7'b0000000));    // external subtitle
    send_request(make_req(0, TrkAudio, 64'd1000, 0));
    send_request(make_req(0, TrkVideo, 64'd5000, 0));
    send_request(make_req(0, TrkAudio, 64'd1020, 7'b0001000));
    send_request(make_req(0, TrkAudio, 64'd90000, 0));         // forward jump
    send_request(make_req(0, TrkVideo, 64'd2000, 0));          // backward step
    send_request(make_req(0, TrkAudio, 64'd500000, 7'b0000100)); // switch, large
    send_request(make_req(0, TrkAudio, 64'd520000, 7'b0000110)); // switch, disc
    send_request(make_req(0, TrkAudio, 64'd530000, 7'b0010000)); // dropped
    send_request(make_req(0, TrkTag, 64'd0, 0));
    send_request(make_req(0, TrkAudio, 64'd0, 7'b0100000));    // audio gone
    send_request(make_req(0, TrkVideo, 64'd6000, 0));
    send_request(make_req(0, TrkAudio, 64'd7000, 7'b1100000)); // new format wins
    send_request(make_req(0, TrkVideo, 64'd0, 7'b0100000));    // video gone
    send_request(make_req(0, TrkAudio, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    send_request(make_req(0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F));
    send_request(make_req(0, TrkSub, 64'd10, 7'b0100001));
    send_request(make_req(1, TrkAudio, 64'hFFFF_FFFF_FFFF_F000, 0)); // seek, negative base
    send_request(make_req(0, TrkTag, 64'd1, 0));
    send_request(make_req(0, TrkVideo, 64'd100, 7'b1000000));
    send_request(make_req(0, TrkSub, 64'd50, 7'b0000001));
    send_request(make_req(1, TrkVideo, 64'd0, 0));
    wait_idle();

    // Pressure: receiver holds while the sender keeps offering.
    hold_off = 1;
    repeat (2) @(posedge clk);
    hold_off = 0;
    random_stream(60);
    wait_idle();

    // Phases over register settings, extremes included.
    write_reg(RegJumpThr, 32'd0); write_reg(RegBackThr, 32'd0);
    write_reg(RegSwitchThr, 32'd0); write_reg(RegMergeDelta, 32'd0);
    write_reg(RegUnsyncLimit, 32'd0);
    random_stream(200);
    wait_idle();
    write_reg(RegJumpThr, 32'hFFFF_FFFF); write_reg(RegBackThr, 32'hFFFF_FFFF);
    write_reg(RegSwitchThr, 32'hFFFF_FFFF); write_reg(RegMergeDelta, 32'hFFFF_FFFF);
    write_reg(RegUnsyncLimit, 32'h0000_FFFF);
    random_stream(180);
    wait_idle();
    write_reg(RegJumpThr, 32'd5000); write_reg(RegBackThr, 32'd300);
    write_reg(RegSwitchThr, 32'd50000); write_reg(RegMergeDelta, 32'd100);
    write_reg(RegUnsyncLimit, 32'd5);
    random_stream(200);
    wait_idle();
    write_reg(RegJumpThr, $urandom); write_reg(RegBackThr, $urandom_range(0, 5000));
    write_reg(RegSwitchThr, $urandom); write_reg(RegMergeDelta, $urandom_range(0, 3000));
    write_reg(RegUnsyncLimit, $urandom_range(0, 20));
    random_stream(190);
    wait_idle();

    done = 1;
    if (fail_count == 0)
      $display("[av_timestamp_rebaser_top] OK");
    else
      $display("[av_timestamp_rebaser_top] ERROR");
    $finish;
  end
endmodule
